@@ hdl/clip_peak_normalizer_core_assert.svh @@
// Assertion macros for the clip peak normalizer RTL.
`ifndef CLIP_PEAK_NORMALIZER_CORE_ASSERT_SVH
`define CLIP_PEAK_NORMALIZER_CORE_ASSERT_SVH

// Same-cycle implication, checked only outside reset.
`define CLPN_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("clpn: same-cycle check failed");

// Next-cycle implication, checked only outside reset.
`define CLPN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("clpn: next-cycle check failed");

`endif

@@ hdl/clpn_pkg.sv @@
// Types, constants and codes shared by the clip peak normalizer modules.
package clpn_pkg;

  // Clip store geometry.
  localparam int unsigned CLIP_DEPTH = 16384;
  localparam int unsigned ADDR_W     = $clog2(CLIP_DEPTH);
  localparam int unsigned CNT_W      = $clog2(CLIP_DEPTH + 1);

  // Field and datapath widths.
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned PEAK_W     = 16;
  localparam int unsigned TARGET_W   = 15;
  localparam int unsigned MINP_W     = 15;
  localparam int unsigned GAIN_W     = 22;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned QUO_W      = TARGET_W + FRAC_W;
  localparam int unsigned PROD_W     = PEAK_W + GAIN_W;
  localparam int unsigned RND_W      = PROD_W - FRAC_W + 1;
  localparam int unsigned DIV_STEPS  = QUO_W;
  localparam int unsigned STEP_W     = $clog2(DIV_STEPS);
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = GAIN_W;

  // Fixed values.
  localparam logic [GAIN_W-1:0]   UNITY_Q16  = GAIN_W'(65536);
  localparam logic [TARGET_W-1:0] TARGET_RST = TARGET_W'(29490);
  localparam logic [MINP_W-1:0]   MINP_RST   = MINP_W'(16);
  localparam logic [GAIN_W-1:0]   MAXG_RST   = GAIN_W'(2097152);
  localparam logic [FRAC_W-1:0]   HALF_LSB   = FRAC_W'(32768);
  localparam logic [RND_W-1:0]    POS_LIMIT  = RND_W'(32767);
  localparam logic [RND_W-1:0]    NEG_LIMIT  = RND_W'(32768);

  // Operation carried by an input transfer.
  typedef enum logic [0:0] {
    OP_PUSH = 1'b0,
    OP_PULL = 1'b1
  } opcode_e;

  // Status reported with each result.
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET = 2'd0,
    CFG_MINP   = 2'd1,
    CFG_MAXG   = 2'd2
  } cfg_idx_e;

  // Input item.
  typedef struct packed {
    opcode_e                    opcode;
    logic signed [SAMPLE_W-1:0] sample_in;
  } in_t;

  // Result item.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       last_sample;
    status_e                    status;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    push;
    logic    div_start;
    logic    div_step;
    logic    gain_div;
    logic    gain_unity;
    logic    mul;
    logic    emit_sample;
    logic    emit_status;
    status_e emit_code;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic gain_ready;
    logic peak_gt_min;
    logic out_free;
  } stat_t;

endpackage

@@ hdl/clpn_if.sv @@
// Handshake interfaces for the input, result and configuration channels.
interface clpn_in_if;
  import clpn_pkg::*;
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface clpn_out_if;
  import clpn_pkg::*;
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface clpn_cfg_if;
  import clpn_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_idx;
  logic [CFG_DATA_W-1:0] wdata;
  modport source (output valid, output reg_idx, output wdata, input ready);
  modport sink (input valid, input reg_idx, input wdata, output ready);
endinterface

@@ hdl/clpn_dp.sv @@
// Datapath: clip store, clip bookkeeping, gain divider, scaler and result register.
module clpn_dp import clpn_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cmd_t                       cmd_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output out_t                       out_data_o,
  output stat_t                      stat_o
);

  logic [TARGET_W-1:0] target_q;
  logic [MINP_W-1:0]   minp_q;
  logic [GAIN_W-1:0]   maxg_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    read_q, read_d;
  logic [PEAK_W-1:0]   peak_q, peak_d;
  logic [GAIN_W-1:0]   gain_q, gain_d;
  logic                gain_rdy_q, gain_rdy_d;
  logic [QUO_W-1:0]    dq_q;
  logic [PEAK_W-1:0]   rem_q;
  logic [SAMPLE_W-1:0] rd_q;
  logic [PROD_W-1:0]   prod_q;
  logic                neg_q;
  logic                out_valid_q;
  out_t                out_q, out_d;
  logic [SAMPLE_W-1:0] mem [CLIP_DEPTH];

  logic [PEAK_W-1:0]   push_mag;
  logic [PEAK_W-1:0]   rd_mag;
  logic [PEAK_W:0]     rem_shift;
  logic                rem_ge;
  logic [PEAK_W-1:0]   rem_next;
  logic [GAIN_W-1:0]   gain_capped;
  logic [CNT_W-1:0]    read_inc;
  logic                is_last;
  logic [RND_W-2:0]    q_trunc;
  logic [FRAC_W-1:0]   q_frac;
  logic                round_up;
  logic [RND_W-1:0]    q_round;
  logic [SAMPLE_W-1:0] pos_res;
  logic [SAMPLE_W:0]   neg_mag;
  logic [SAMPLE_W-1:0] neg_res;

  // Magnitudes of the pushed sample and of the stored sample being played.
  assign push_mag = sample_i[SAMPLE_W-1] ? PEAK_W'(-sample_i) : PEAK_W'(sample_i);
  assign rd_mag   = rd_q[SAMPLE_W-1] ? PEAK_W'(-rd_q) : rd_q;

  // One restoring division step: shift in a dividend bit, subtract if it fits.
  assign rem_shift = {rem_q, dq_q[QUO_W-1]};
  assign rem_ge    = rem_shift >= {1'b0, peak_q};
  assign rem_next  = rem_ge ? PEAK_W'(rem_shift - {1'b0, peak_q}) : PEAK_W'(rem_shift);

  // The quotient is limited by the gain ceiling.
  assign gain_capped = (dq_q > QUO_W'(maxg_q)) ? maxg_q : dq_q[GAIN_W-1:0];

  // Round half to even, then saturate to the signed sample range.
  assign q_trunc  = prod_q[PROD_W-1:FRAC_W];
  assign q_frac   = prod_q[FRAC_W-1:0];
  assign round_up = (q_frac > HALF_LSB) || ((q_frac == HALF_LSB) && q_trunc[0]);
  assign q_round  = {1'b0, q_trunc} + RND_W'(round_up);
  assign pos_res  = (q_round > POS_LIMIT) ? POS_LIMIT[SAMPLE_W-1:0] : q_round[SAMPLE_W-1:0];
  assign neg_mag  = (q_round > NEG_LIMIT) ? NEG_LIMIT[SAMPLE_W:0] : q_round[SAMPLE_W:0];
  assign neg_res  = SAMPLE_W'((SAMPLE_W + 1)'(0) - neg_mag);

  // End of clip detection for the sample being emitted.
  assign read_inc = read_q + CNT_W'(1);
  assign is_last  = read_inc >= count_q;

  // Clip bookkeeping and gain state.
  always_comb begin
    count_d    = count_q;
    read_d     = read_q;
    peak_d     = peak_q;
    gain_d     = gain_q;
    gain_rdy_d = gain_rdy_q;
    if (cmd_i.push) begin
      count_d = count_q + CNT_W'(1);
      if (push_mag > peak_q) begin
        peak_d = push_mag;
      end
    end
    if (cmd_i.gain_unity) begin
      gain_d     = UNITY_Q16;
      gain_rdy_d = 1'b1;
    end
    if (cmd_i.gain_div) begin
      gain_d     = gain_capped;
      gain_rdy_d = 1'b1;
    end
    if (cmd_i.emit_sample) begin
      if (is_last) begin
        count_d    = '0;
        read_d     = '0;
        peak_d     = '0;
        gain_d     = UNITY_Q16;
        gain_rdy_d = 1'b0;
      end else begin
        read_d = read_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      read_q     <= '0;
      peak_q     <= '0;
      gain_q     <= UNITY_Q16;
      gain_rdy_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      read_q     <= read_d;
      peak_q     <= peak_d;
      gain_q     <= gain_d;
      gain_rdy_q <= gain_rdy_d;
    end
  end

  // Configuration registers; writes to unused indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TARGET_RST;
      minp_q   <= MINP_RST;
      maxg_q   <= MAXG_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TARGET: target_q <= cfg_data_i[TARGET_W-1:0];
        CFG_MINP:   minp_q   <= cfg_data_i[MINP_W-1:0];
        CFG_MAXG:   maxg_q   <= cfg_data_i[GAIN_W-1:0];
        default:    ;
      endcase
    end
  end

  // Clip store: one write port for pushes, one registered read at the play position.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[count_q[ADDR_W-1:0]] <= sample_i;
    end
    rd_q <= mem[read_q[ADDR_W-1:0]];
  end

  // Divider registers: dividend shifts out as quotient bits shift in.
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dq_q  <= {target_q, FRAC_W'(0)};
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dq_q  <= {dq_q[QUO_W-2:0], rem_ge};
      rem_q <= rem_next;
    end
  end

  // Product of sample magnitude and gain.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= rd_mag * gain_q;
      neg_q  <= rd_q[SAMPLE_W-1];
    end
  end

  // Result register contents.
  always_comb begin
    out_d = out_q;
    if (cmd_i.emit_sample) begin
      out_d.sample_out  = neg_q ? neg_res : pos_res;
      out_d.last_sample = is_last;
      out_d.status      = STAT_OK;
    end else if (cmd_i.emit_status) begin
      out_d.sample_out  = '0;
      out_d.last_sample = 1'b0;
      out_d.status      = cmd_i.emit_code;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // Result valid flag: set on a load, cleared when the transfer completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_sample || cmd_i.emit_status) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Status toward the controller.
  assign stat_o.full        = count_q >= CNT_W'(CLIP_DEPTH);
  assign stat_o.empty       = read_q >= count_q;
  assign stat_o.gain_ready  = gain_rdy_q;
  assign stat_o.peak_gt_min = peak_q > PEAK_W'(minp_q);
  assign stat_o.out_free    = !out_valid_q || out_ready_i;

endmodule

@@ hdl/clpn_ctrl.sv @@
// Controller: sequences pushes, the gain division, scaling and result loads.
module clpn_ctrl import clpn_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  opcode_e opcode_i,
  input  stat_t   stat_i,
  output logic    in_ready_o,
  output cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_GAIN = 6'b000100,
    S_MUL  = 6'b001000,
    S_RND  = 6'b010000,
    S_EMIT = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  status_e           code_q, code_d;

  // Next state and command decode.
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    code_d     = code_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (opcode_i == OP_PUSH) begin
            if (stat_i.full) begin
              code_d  = STAT_FULL;
              state_d = S_EMIT;
            end else begin
              cmd_o.push = 1'b1;
            end
          end else if (stat_i.empty) begin
            code_d  = STAT_EMPTY;
            state_d = S_EMIT;
          end else if (stat_i.gain_ready) begin
            state_d = S_MUL;
          end else if (stat_i.peak_gt_min) begin
            cmd_o.div_start = 1'b1;
            step_d          = '0;
            state_d         = S_DIV;
          end else begin
            cmd_o.gain_unity = 1'b1;
            state_d          = S_MUL;
          end
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + STEP_W'(1);
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          state_d = S_GAIN;
        end
      end
      S_GAIN: begin
        cmd_o.gain_div = 1'b1;
        state_d        = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_RND;
      end
      S_RND: begin
        if (stat_i.out_free) begin
          cmd_o.emit_sample = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_EMIT: begin
        cmd_o.emit_code = code_q;
        if (stat_i.out_free) begin
          cmd_o.emit_status = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      code_q  <= STAT_OK;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      code_q  <= code_d;
    end
  end

endmodule

@@ hdl/clip_peak_normalizer_core.sv @@
// Top level of the clip peak normalizer: controller, datapath and channel wiring.
//
//   channel    dir   modport  payload
//   in_ch_i    in    sink     opcode, sample_in
//   out_ch_o   out   source   sample_out, last_sample, status
//   cfg_ch_i   in    sink     reg_idx, wdata (always ready)
//
// A pull runs the store read, multiply, and round and load; the first pull
// of a clip whose peak exceeds the minimum adds the gain division, one
// quotient bit per cycle. Empty pulls and dropped pushes load a status.
// A result waits in the output register; a new item is taken while it waits,
// and the block stalls only when a second result is ready before the first
// transfer. Reset is asynchronous; the clip store needs no clearing pass.
`include "clip_peak_normalizer_core_assert.svh"

module clip_peak_normalizer_core import clpn_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  clpn_in_if.sink     in_ch_i,
  clpn_out_if.source  out_ch_o,
  clpn_cfg_if.sink    cfg_ch_i
);

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  // Configuration writes are taken in any cycle.
  assign cfg_ch_i.ready = 1'b1;
  assign in_ch_i.ready  = in_ready;

  clpn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch_i.valid),
    .opcode_i   (in_ch_i.data.opcode),
    .stat_i     (stat),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  clpn_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sample_i    (in_ch_i.data.sample_in),
    .cfg_we_i    (cfg_ch_i.valid),
    .cfg_idx_i   (cfg_ch_i.reg_idx),
    .cfg_data_i  (cfg_ch_i.wdata),
    .out_ready_i (out_ch_o.ready),
    .out_valid_o (out_ch_o.valid),
    .out_data_o  (out_ch_o.data),
    .stat_o      (stat)
  );

  // The final sample of a clip is always a normal result.
  `CLPN_ASSERT_SAME(a_last_is_ok, out_ch_o.valid && out_ch_o.data.last_sample, out_ch_o.data.status == STAT_OK)

  // Error results carry a zero sample and no end-of-clip mark.
  `CLPN_ASSERT_SAME(a_error_zero, out_ch_o.valid && (out_ch_o.data.status != STAT_OK), (out_ch_o.data.sample_out == '0) && !out_ch_o.data.last_sample)

  // A pull occupies the controller for at least the following cycle.
  `CLPN_ASSERT_NEXT(a_pull_busy, in_ch_i.valid && in_ready && (in_ch_i.data.opcode == OP_PULL), !in_ready)

  // Loading a gain marks it ready for the rest of the clip.
  `CLPN_ASSERT_NEXT(a_gain_set, cmd.gain_div || cmd.gain_unity, stat.gain_ready)

endmodule
